// File: sv/cubic_bspline_evaluator_macros.svh
// ----------------------------------------------------------------------------
// cubic_bspline_evaluator_macros
// assertion helpers shared by the evaluator rtl
// ----------------------------------------------------------------------------
`ifndef CUBIC_BSPLINE_EVALUATOR_MACROS_SVH
`define CUBIC_BSPLINE_EVALUATOR_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define CBSE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define CBSE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/cbse_pkg.sv
// ----------------------------------------------------------------------------
// cbse_pkg
// types, codes and datapath widths of the cubic b-spline evaluator
// ----------------------------------------------------------------------------
package cbse_pkg;

  // field widths
  localparam int X_W      = 20;
  localparam int CIDX_W   = 6;
  localparam int C_W      = 24;
  localparam int VAL_W    = 32;
  localparam int INV_W    = 20;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 20;
  localparam logic [CFG_IDX_W-1:0] CFG_X_MIN    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_STEP = 1'b1;
  localparam logic signed [X_W-1:0] X_MIN_RST    = -20'sd20480;
  localparam logic [INV_W-1:0]      INV_STEP_RST = 20'd1638;

  // request opcodes
  localparam logic OP_EVAL = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  // coefficient table, split into even and odd banks
  localparam int NODES_DEF   = 62;
  localparam int TABLE_DEPTH = 64;
  localparam int BANK_DEPTH  = TABLE_DEPTH / 2;
  localparam int BANK_AW     = CIDX_W - 1;

  // datapath widths
  localparam int D_W      = X_W + 1;
  localparam int P_W      = D_W + INV_W;
  localparam int FRAC_LSB = 12;
  localparam int INT_LSB  = 24;
  localparam int M_W      = P_W - INT_LSB;
  localparam int I_W      = M_W + 1;
  localparam int T_W      = 12;
  localparam int S_W      = T_W + 1;
  localparam int T2_W     = 2 * T_W;
  localparam int S2_W     = 2 * T_W + 1;
  localparam int T3_W     = 3 * T_W;
  localparam int S3_W     = 3 * T_W + 1;
  localparam int W_W      = 39;
  localparam int WLO_W    = 20;
  localparam int WHI_W    = W_W - WLO_W;
  localparam int PL_W     = C_W + WLO_W;
  localparam int PH_W     = C_W + WHI_W;
  localparam int PROD_W   = 62;
  localparam int SUM_W    = 63;
  localparam int ROUND_SH = 36;
  localparam int R_W      = SUM_W - ROUND_SH;
  localparam int W_ONE_SH = 36;

  localparam logic [S_W-1:0] ONE_Q12 = 13'd4096;

  typedef struct packed {
    logic                    op;
    logic [CIDX_W-1:0]       coeff_index;
    logic signed [C_W-1:0]   coeff_value;
    logic signed [X_W-1:0]   x;
  } in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    outside;
    logic                    saturated;
  } out_t;

endpackage

// File: sv/cubic_bspline_evaluator.sv
// ----------------------------------------------------------------------------
// cubic_bspline_evaluator
// uniform cubic b-spline evaluation over a 64-entry coefficient table
// ----------------------------------------------------------------------------
//
//  channel  ports                          direction  carries
//  -------  -----------------------------  ---------  ----------------------------
//  in       in_valid  in_stall  in_data    sink       load or evaluate request
//  out      out_valid out_stall out_data   source     spline value per evaluate
//  cfg      cfg_we cfg_index cfg_wdata     sink       x_min, inv_step writes
//
//  one request per cycle while in_stall is low; an evaluate result passes
//  through ten registers, the first loaded at acceptance
//  throughput is set by the two-bank table: four taps are read through two
//  dual-read banks in the same cycle, so no evaluate ever waits on a port
//  loads take a pipeline slot and give no result
//  reset (rst_n low, synchronous) empties the pipeline and reloads x_min and
//  inv_step; the table itself is not cleared
//  out_stall only holds stages that are full; bubbles close up, so requests
//  keep entering while a result waits in the output register
//
`include "cubic_bspline_evaluator_macros.svh"

module cubic_bspline_evaluator #(
  parameter int NODES = cbse_pkg::NODES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  cbse_pkg::in_t                    in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output cbse_pkg::out_t                   out_data,
  input  logic                             cfg_we,
  input  logic [cbse_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cbse_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  import cbse_pkg::*;

  // highest basis index that has a table slot
  localparam int LIMIT = (NODES + 1 < TABLE_DEPTH - 1) ? NODES + 1 : TABLE_DEPTH - 1;

  localparam logic signed [VAL_W:0] VMAX = {2'b00, {(VAL_W - 1){1'b1}}};
  localparam logic signed [VAL_W:0] VMIN = {2'b11, {(VAL_W - 1){1'b0}}};

  // configuration
  logic signed [X_W-1:0] x_min_r;
  logic [INV_W-1:0]      inv_step_r;

  // stage enables: output register, then stages 1 to 9
  logic en_out, en1, en2, en3, en4, en5, en6, en7, en8, en9;

  // stage 1: offset from first node
  logic                  s1_vld_r;
  logic                  s1_op_r;
  logic [CIDX_W-1:0]     s1_cidx_r;
  logic signed [C_W-1:0] s1_cval_r;
  logic signed [D_W-1:0] s1_d_r, s1_d_nxt;

  // stage 2: grid position
  logic                  s2_vld_r;
  logic                  s2_op_r;
  logic [CIDX_W-1:0]     s2_cidx_r;
  logic signed [C_W-1:0] s2_cval_r;
  logic signed [P_W-1:0] s2_p_r, s2_p_nxt;

  // stage 3: fraction powers, table read issued
  logic                  s3_vld_r;
  logic [T_W-1:0]        s3_t_r, t_nxt;
  logic [S_W-1:0]        s3_s_r, s_nxt;
  logic [T2_W-1:0]       s3_t2_r, t2_nxt;
  logic [S2_W-1:0]       s3_s2_r, s2_nxt;
  logic [3:0]            s3_vmask_r, vmask_nxt;
  logic                  s3_swap_r;
  logic signed [M_W-1:0] m_nxt;
  logic [I_W-1:0]        idx_nxt [4];

  // table banks
  logic                  ram_re, ram_wr, we_ev, we_od;
  logic [BANK_AW-1:0]    ev_a, ev_b, od_a, od_b, waddr;
  logic [C_W-1:0]        ev_da, ev_db, od_da, od_db;

  // stage 4: cubes, tap coefficients
  logic                  s4_vld_r;
  logic [T3_W-1:0]       s4_t3_r, t3_nxt;
  logic [S3_W-1:0]       s4_s3_r, s3c_nxt;
  logic [W_W-1:0]        s4_bt_r, bt_nxt;
  logic [W_W-1:0]        s4_bs_r, bs_nxt;
  logic signed [C_W-1:0] s4_c_r [4];
  logic [C_W-1:0]        craw [4];
  logic signed [C_W-1:0] c_nxt [4];
  logic                  s4_any_r;

  // stage 5: basis weights
  logic                  s5_vld_r;
  logic [W_W-1:0]        s5_w_r [4];
  logic [W_W-1:0]        w_nxt [4];
  logic signed [C_W-1:0] s5_c_r [4];
  logic                  s5_any_r;

  // stage 6: partial products
  logic                   s6_vld_r;
  logic signed [PL_W-1:0] s6_pl_r [4];
  logic signed [PH_W-1:0] s6_ph_r [4];
  logic signed [PL_W-1:0] pl_nxt [4];
  logic signed [PH_W-1:0] ph_nxt [4];
  logic                   s6_any_r;

  // stage 7: tap products
  logic                     s7_vld_r;
  logic signed [PROD_W-1:0] s7_prod_r [4];
  logic signed [PROD_W-1:0] prod_nxt [4];
  logic                     s7_any_r;

  // stage 8: pair sums
  logic                    s8_vld_r;
  logic signed [SUM_W-1:0] s8_lo_r, s8_hi_r, lo_nxt, hi_nxt;
  logic                    s8_any_r;

  // stage 9: full sum
  logic                    s9_vld_r;
  logic signed [SUM_W-1:0] s9_sum_r, sum_nxt;
  logic                    s9_any_r;

  // output register
  logic                    out_vld_r;
  out_t                    out_data_r, out_nxt;
  logic signed [SUM_W-1:0] rnd;
  logic signed [R_W-1:0]   r_q;
  logic signed [VAL_W:0]   r_ext;

  // ------------------------------------------------------------------------
  // configuration writes
  // ------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_min_r    <= X_MIN_RST;
      inv_step_r <= INV_STEP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_X_MIN:    x_min_r    <= $signed(cfg_wdata[X_W-1:0]);
        CFG_INV_STEP: inv_step_r <= cfg_wdata[INV_W-1:0];
        default:      ;
      endcase
    end
  end

  // ------------------------------------------------------------------------
  // flow control: a stage loads when empty or when its successor moves
  // ------------------------------------------------------------------------
  assign en_out   = !out_vld_r || !out_stall;
  assign en9      = !s9_vld_r || en_out;
  assign en8      = !s8_vld_r || en9;
  assign en7      = !s7_vld_r || en8;
  assign en6      = !s6_vld_r || en7;
  assign en5      = !s5_vld_r || en6;
  assign en4      = !s4_vld_r || en5;
  assign en3      = !s3_vld_r || en4;
  assign en2      = !s2_vld_r || en3;
  assign en1      = !s1_vld_r || en2;
  assign in_stall = !en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      s4_vld_r  <= 1'b0;
      s5_vld_r  <= 1'b0;
      s6_vld_r  <= 1'b0;
      s7_vld_r  <= 1'b0;
      s8_vld_r  <= 1'b0;
      s9_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (en1)    s1_vld_r  <= in_valid;
      if (en2)    s2_vld_r  <= s1_vld_r;
      // loads end at the table write
      if (en3)    s3_vld_r  <= s2_vld_r && (s2_op_r == OP_EVAL);
      if (en4)    s4_vld_r  <= s3_vld_r;
      if (en5)    s5_vld_r  <= s4_vld_r;
      if (en6)    s6_vld_r  <= s5_vld_r;
      if (en7)    s7_vld_r  <= s6_vld_r;
      if (en8)    s8_vld_r  <= s7_vld_r;
      if (en9)    s9_vld_r  <= s8_vld_r;
      if (en_out) out_vld_r <= s9_vld_r;
    end
  end

  // ------------------------------------------------------------------------
  // stages 1 and 2: offset, then scale to grid units (q24)
  // ------------------------------------------------------------------------
  assign s1_d_nxt = {in_data.x[X_W-1], in_data.x} - {x_min_r[X_W-1], x_min_r};
  assign s2_p_nxt = s1_d_r * $signed({1'b0, inv_step_r});

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_op_r   <= in_data.op;
      s1_cidx_r <= in_data.coeff_index;
      s1_cval_r <= in_data.coeff_value;
      s1_d_r    <= s1_d_nxt;
    end
    if (en2) begin
      s2_op_r   <= s1_op_r;
      s2_cidx_r <= s1_cidx_r;
      s2_cval_r <= s1_cval_r;
      s2_p_r    <= s2_p_nxt;
    end
  end

  // ------------------------------------------------------------------------
  // stage 3: interval split, tap indices and table access
  // taps m..m+3 are consecutive, so two land in each bank
  // ------------------------------------------------------------------------
  assign m_nxt  = s2_p_r[P_W-1:INT_LSB];
  assign t_nxt  = s2_p_r[INT_LSB-1:FRAC_LSB];
  assign s_nxt  = ONE_Q12 - {1'b0, t_nxt};
  assign t2_nxt = t_nxt * t_nxt;
  assign s2_nxt = s_nxt * s_nxt;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      idx_nxt[k]   = {m_nxt[M_W-1], m_nxt} + I_W'(k);
      // below zero or past the last node counts as no tap
      vmask_nxt[k] = !idx_nxt[k][I_W-1] && (idx_nxt[k] <= I_W'(LIMIT));
    end
  end

  // even m: m, m+2 in the even bank; odd m: m+1, m+3
  assign ev_a = m_nxt[0] ? idx_nxt[1][CIDX_W-1:1] : idx_nxt[0][CIDX_W-1:1];
  assign ev_b = m_nxt[0] ? idx_nxt[3][CIDX_W-1:1] : idx_nxt[2][CIDX_W-1:1];
  assign od_a = m_nxt[0] ? idx_nxt[0][CIDX_W-1:1] : idx_nxt[1][CIDX_W-1:1];
  assign od_b = m_nxt[0] ? idx_nxt[2][CIDX_W-1:1] : idx_nxt[3][CIDX_W-1:1];

  // writes and reads happen in the same stage, so request order is kept
  assign ram_re = en3;
  assign ram_wr = en3 && s2_vld_r && (s2_op_r == OP_LOAD);
  assign we_ev  = ram_wr && !s2_cidx_r[0];
  assign we_od  = ram_wr && s2_cidx_r[0];
  assign waddr  = s2_cidx_r[CIDX_W-1:1];

  cbse_ram #(
    .WIDTH (C_W),
    .DEPTH (BANK_DEPTH)
  ) u_bank_even (
    .clk     (clk),
    .we      (we_ev),
    .waddr   (waddr),
    .wdata   (s2_cval_r),
    .re      (ram_re),
    .raddr_a (ev_a),
    .raddr_b (ev_b),
    .rdata_a (ev_da),
    .rdata_b (ev_db)
  );

  cbse_ram #(
    .WIDTH (C_W),
    .DEPTH (BANK_DEPTH)
  ) u_bank_odd (
    .clk     (clk),
    .we      (we_od),
    .waddr   (waddr),
    .wdata   (s2_cval_r),
    .re      (ram_re),
    .raddr_a (od_a),
    .raddr_b (od_b),
    .rdata_a (od_da),
    .rdata_b (od_db)
  );

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_t_r     <= t_nxt;
      s3_s_r     <= s_nxt;
      s3_t2_r    <= t2_nxt;
      s3_s2_r    <= s2_nxt;
      s3_vmask_r <= vmask_nxt;
      s3_swap_r  <= m_nxt[0];
    end
  end

  // ------------------------------------------------------------------------
  // stage 4: cubes and the constant part of the middle weights
  //   base = 1 + 3f + 3f^2 in q36
  // ------------------------------------------------------------------------
  assign t3_nxt  = s3_t2_r * s3_t_r;
  assign s3c_nxt = s3_s2_r * s3_s_r;
  assign bt_nxt  = (W_W'(1) << W_ONE_SH)
                 + (W_W'(s3_t_r) << (INT_LSB + 1)) + (W_W'(s3_t_r) << INT_LSB)
                 + (W_W'(s3_t2_r) << (FRAC_LSB + 1)) + (W_W'(s3_t2_r) << FRAC_LSB);
  assign bs_nxt  = (W_W'(1) << W_ONE_SH)
                 + (W_W'(s3_s_r) << (INT_LSB + 1)) + (W_W'(s3_s_r) << INT_LSB)
                 + (W_W'(s3_s2_r) << (FRAC_LSB + 1)) + (W_W'(s3_s2_r) << FRAC_LSB);

  // undo the bank swap, tap k holds index m+k
  assign craw[0] = s3_swap_r ? od_da : ev_da;
  assign craw[1] = s3_swap_r ? ev_da : od_da;
  assign craw[2] = s3_swap_r ? od_db : ev_db;
  assign craw[3] = s3_swap_r ? ev_db : od_db;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      c_nxt[k] = s3_vmask_r[k] ? $signed(craw[k]) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_t3_r  <= t3_nxt;
      s4_s3_r  <= s3c_nxt;
      s4_bt_r  <= bt_nxt;
      s4_bs_r  <= bs_nxt;
      s4_c_r   <= c_nxt;
      s4_any_r <= |s3_vmask_r;
    end
  end

  // ------------------------------------------------------------------------
  // stage 5: weights per tap
  //   m   -> s^3, m+1 -> mirrored form, m+2 -> rising form, m+3 -> t^3
  // ------------------------------------------------------------------------
  assign w_nxt[0] = W_W'(s4_s3_r);
  assign w_nxt[1] = s4_bs_r - (W_W'(s4_s3_r) << 1) - W_W'(s4_s3_r);
  assign w_nxt[2] = s4_bt_r - (W_W'(s4_t3_r) << 1) - W_W'(s4_t3_r);
  assign w_nxt[3] = W_W'(s4_t3_r);

  always_ff @(posedge clk) begin
    if (en5) begin
      s5_w_r   <= w_nxt;
      s5_c_r   <= s4_c_r;
      s5_any_r <= s4_any_r;
    end
  end

  // ------------------------------------------------------------------------
  // stages 6 and 7: coefficient times weight, weight split in two halves
  // ------------------------------------------------------------------------
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      pl_nxt[k] = s5_c_r[k] * $signed({1'b0, s5_w_r[k][WLO_W-1:0]});
      ph_nxt[k] = s5_c_r[k] * $signed({1'b0, s5_w_r[k][W_W-1:WLO_W]});
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      prod_nxt[k] = $signed({s6_ph_r[k][PROD_W-WLO_W-1:0], {WLO_W{1'b0}}})
                  + $signed({{(PROD_W - PL_W){s6_pl_r[k][PL_W-1]}}, s6_pl_r[k]});
    end
  end

  always_ff @(posedge clk) begin
    if (en6) begin
      s6_pl_r  <= pl_nxt;
      s6_ph_r  <= ph_nxt;
      s6_any_r <= s5_any_r;
    end
    if (en7) begin
      s7_prod_r <= prod_nxt;
      s7_any_r  <= s6_any_r;
    end
  end

  // ------------------------------------------------------------------------
  // stages 8 and 9: sum of taps in q48
  // ------------------------------------------------------------------------
  assign lo_nxt  = {s7_prod_r[0][PROD_W-1], s7_prod_r[0]}
                 + {s7_prod_r[1][PROD_W-1], s7_prod_r[1]};
  assign hi_nxt  = {s7_prod_r[2][PROD_W-1], s7_prod_r[2]}
                 + {s7_prod_r[3][PROD_W-1], s7_prod_r[3]};
  assign sum_nxt = s8_lo_r + s8_hi_r;

  always_ff @(posedge clk) begin
    if (en8) begin
      s8_lo_r  <= lo_nxt;
      s8_hi_r  <= hi_nxt;
      s8_any_r <= s7_any_r;
    end
    if (en9) begin
      s9_sum_r <= sum_nxt;
      s9_any_r <= s8_any_r;
    end
  end

  // ------------------------------------------------------------------------
  // output: round half up to q12, clip to 32 bits, zero when no tap
  // ------------------------------------------------------------------------
  assign rnd   = s9_sum_r + (SUM_W'(1) << (ROUND_SH - 1));
  assign r_q   = rnd[SUM_W-1:ROUND_SH];
  assign r_ext = {{(VAL_W + 1 - R_W){r_q[R_W-1]}}, r_q};

  always_comb begin
    out_nxt = '0;
    if (!s9_any_r) begin
      out_nxt.outside = 1'b1;
    end else if (r_ext > VMAX) begin
      out_nxt.value     = VMAX[VAL_W-1:0];
      out_nxt.saturated = 1'b1;
    end else if (r_ext < VMIN) begin
      out_nxt.value     = VMIN[VAL_W-1:0];
      out_nxt.saturated = 1'b1;
    end else begin
      out_nxt.value = r_ext[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  // ------------------------------------------------------------------------
  // checks
  // ------------------------------------------------------------------------
  // a result with no tap carries a clean zero
  `CBSE_ASSERT_IMP(a_outside_zero, out_vld_r && out_data_r.outside, (out_data_r.value == '0) && !out_data_r.saturated, "outside result not zero")
  // the tap sum stays well inside 32 bits after rounding
  `CBSE_ASSERT_IMP(a_no_clip, out_vld_r, !out_data_r.saturated, "unexpected clipping")
  // a table write never turns into a result
  `CBSE_ASSERT_NXT(a_load_no_result, ram_wr, !s3_vld_r, "load request entered result path")
  // an empty output register never holds off the input
  `CBSE_ASSERT_IMP(a_empty_no_stall, !out_vld_r, !in_stall, "input stalled with empty output")

endmodule

// File: sv/cbse_ram.sv
// ----------------------------------------------------------------------------
// cbse_ram
// generic ram, one write port and two registered read ports
// ----------------------------------------------------------------------------
module cbse_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds while re is low
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the cubic b-spline evaluator
// ----------------------------------------------------------------------------
// Fills the coefficient table, then sends evaluate and load requests under
// several x_min and inv_step settings. These include the register extremes.
// A scoreboard class predicts each spline value in 64-bit exact arithmetic
// and checks every result in order. The sender runs in random bursts and the
// receiver stalls on a pattern of its own.
// ----------------------------------------------------------------------------

import cbse_pkg::*;

class spline_scoreboard;
  longint      x_min_q12;
  longint      inv_step_q12;
  longint      coeffs [TABLE_DEPTH];
  out_t        pending_values [$];
  int unsigned errors;
  int unsigned loads_seen;
  int unsigned evals_seen;
  int unsigned results_checked;
  int unsigned outside_seen;

  localparam longint VAL_MAX = 64'sd2147483647;
  localparam longint VAL_MIN = -64'sd2147483648;

  function new();
    x_min_q12    = longint'(X_MIN_RST);
    inv_step_q12 = longint'(INV_STEP_RST);
    foreach (coeffs[k]) coeffs[k] = 0;
  endfunction

  function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    if (idx == CFG_X_MIN) x_min_q12 = longint'($signed(data));
    else if (idx == CFG_INV_STEP) inv_step_q12 = longint'(data);
  endfunction

  // exact spline value: Q48 weighted sum, rounded half up to Q12, clipped
  function out_t eval_spline(logic signed [X_W-1:0] x);
    longint d, p, m, t, s, j, acc, r;
    longint w [4];
    longint idx [4];
    bit     hit;
    out_t   res;
    d = longint'(x) - x_min_q12;
    p = d * inv_step_q12;
    m = p >>> 24;
    t = (p >>> 12) & 64'sd4095;
    s = 4096 - t;
    j = m + 1;
    w[0] = t * t * t;
    w[1] = (longint'(1) <<< 36) + ((3 * t) <<< 24) + ((3 * t * t) <<< 12) - 3 * t * t * t;
    w[2] = (longint'(1) <<< 36) + ((3 * s) <<< 24) + ((3 * s * s) <<< 12) - 3 * s * s * s;
    w[3] = s * s * s;
    idx[0] = j + 2;
    idx[1] = j + 1;
    idx[2] = j;
    idx[3] = j - 1;
    acc = 0;
    hit = 1'b0;
    for (int k = 0; k < 4; k++) begin
      if (idx[k] >= 0 && idx[k] <= NODES_DEF + 1 && idx[k] < TABLE_DEPTH) begin
        hit = 1'b1;
        acc += coeffs[int'(idx[k])] * w[k];
      end
    end
    r = (acc + (longint'(1) <<< 35)) >>> 36;
    res.saturated = 1'b0;
    if (r > VAL_MAX) begin
      r = VAL_MAX;
      res.saturated = 1'b1;
    end else if (r < VAL_MIN) begin
      r = VAL_MIN;
      res.saturated = 1'b1;
    end
    if (!hit) begin
      r = 0;
      res.saturated = 1'b0;
    end
    res.value   = r[VAL_W-1:0];
    res.outside = !hit;
    return res;
  endfunction

  function void note_request(in_t req);
    if (req.op == OP_LOAD) begin
      coeffs[req.coeff_index] = longint'(req.coeff_value);
      loads_seen++;
    end else begin
      pending_values.push_back(eval_spline(req.x));
      evals_seen++;
    end
  endfunction

  function void check_result(out_t got);
    out_t want;
    if (pending_values.size() == 0) begin
      $display("%0t: unexpected result value=%0d outside=%0b saturated=%0b",
               $time, got.value, got.outside, got.saturated);
      errors++;
      return;
    end
    want = pending_values.pop_front();
    results_checked++;
    if (want.outside) outside_seen++;
    if (got.value !== want.value) begin
      $display("%0t: value mismatch expected %0d actual %0d", $time, want.value, got.value);
      errors++;
    end
    if (got.outside !== want.outside) begin
      $display("%0t: outside mismatch expected %0b actual %0b",
               $time, want.outside, got.outside);
      errors++;
    end
    if (got.saturated !== want.saturated) begin
      $display("%0t: saturated mismatch expected %0b actual %0b",
               $time, want.saturated, got.saturated);
      errors++;
    end
  endfunction

  function int pending_count();
    return pending_values.size();
  endfunction
endclass

module tb;

  // pause after the last result is back; it covers loads still in flight
  localparam int DRAIN_CYCLES = 30;
  // cycles with no request and no result accepted before the run is called hung
  localparam int STALL_LIMIT = 4000;
  localparam int RAND_PER_PHASE = 190;
  localparam int NUM_PHASES = 7;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_t                   in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_t                  out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_X_MIN;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  spline_scoreboard sb = new();
  in_t              request_queue [$];
  int               idle_cycles = 0;
  int               settings_used = 1;

  cubic_bspline_evaluator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // accepted requests feed the predictor, accepted results get checked
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_request(in_data);
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d results still expected",
                 $time, STALL_LIMIT, sb.pending_count());
        $display("Test completed with failures");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // receiver back-pressure: a new mode each time stall_tick wraps, never stalling forever
  logic [5:0] stall_tick = '0;
  logic [1:0] stall_mode = '0;
  logic [7:0] stall_pattern = '0;
  always @(negedge clk) begin
    stall_tick <= stall_tick + 1'b1;
    if (stall_tick == '0) begin
      stall_mode    <= 2'($urandom_range(0, 3));
      stall_pattern <= 8'($urandom_range(0, 254));
    end
    case (stall_mode)
      2'd0: out_stall <= 1'b0;
      2'd1: out_stall <= ($urandom_range(0, 3) == 0);
      2'd2: out_stall <= ($urandom_range(0, 9) < 6);
      default: out_stall <= stall_pattern[stall_tick[2:0]];
    endcase
  end

  // x that lands on grid interval m with Q12 fraction frac, clamped to the field
  function automatic logic signed [X_W-1:0] x_on_grid(longint m, longint frac);
    longint target, d, x;
    target = (m <<< 24) + (frac <<< 12);
    d = target / sb.inv_step_q12;
    if (d * sb.inv_step_q12 < target) d++;
    x = sb.x_min_q12 + d;
    if (x > 524287) x = 524287;
    if (x < -524288) x = -524288;
    return x[X_W-1:0];
  endfunction

  function automatic in_t load_request(int unsigned slot, logic signed [C_W-1:0] val);
    in_t req;
    req = in_t'({$urandom, $urandom});
    req.op          = OP_LOAD;
    req.coeff_index = slot[CIDX_W-1:0];
    req.coeff_value = val;
    return req;
  endfunction

  function automatic in_t eval_request(logic signed [X_W-1:0] x);
    in_t req;
    req    = in_t'({$urandom, $urandom});
    req.op = OP_EVAL;
    req.x  = x;
    return req;
  endfunction

  // mostly evaluates aimed at the table, some anywhere, a quarter loads
  function automatic in_t random_request();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 25) return load_request($urandom_range(0, TABLE_DEPTH - 1), C_W'($urandom));
    if (pick < 75)
      return eval_request(x_on_grid(longint'($urandom_range(0, 69)) - 3,
                                    longint'($urandom_range(0, 4095))));
    return eval_request(X_W'($urandom));
  endfunction

  // one request, held until the block takes it
  task automatic send_request(input in_t req);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic idle_sender(input int unsigned gap);
    @(negedge clk);
    in_valid <= 1'b0;
    in_data  <= in_t'({$urandom, $urandom});
    repeat (gap - 1) @(negedge clk);
  endtask

  // plays the queued requests in random bursts with random gaps
  task automatic play_requests();
    int unsigned burst, gap;
    while (request_queue.size() != 0) begin
      burst = $urandom_range(1, 24);
      gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      while (burst != 0 && request_queue.size() != 0) begin
        send_request(request_queue.pop_front());
        burst--;
      end
      if (gap != 0) idle_sender(gap);
    end
  endtask

  // block is idle once every result is back and loads have left the pipe
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    sb.set_reg(idx, data);
  endtask

  logic signed [X_W-1:0]  phase_x_min    [NUM_PHASES];
  logic [CFG_DATA_W-1:0]  phase_inv_step [NUM_PHASES];
  longint                 edge_m [9] = '{-3, -2, -1, 0, 30, 61, 62, 63, 64};

  initial begin
    // register settings after the reset one: unit grid, both extremes, back to
    // reset, lowest x_min with the largest inv_step, then two random ones
    phase_x_min[0] = 20'sd0;        phase_inv_step[0] = 20'd4096;
    phase_x_min[1] = -20'sd524288;  phase_inv_step[1] = 20'd1;
    phase_x_min[2] = 20'sd524287;   phase_inv_step[2] = 20'd1048575;
    phase_x_min[3] = X_MIN_RST;     phase_inv_step[3] = INV_STEP_RST;
    phase_x_min[4] = -20'sd524288;  phase_inv_step[4] = 20'd1048575;
    phase_x_min[5] = X_W'($urandom);
    phase_inv_step[5] = 20'($urandom_range(256, 20000));
    phase_x_min[6] = X_W'($urandom);
    phase_inv_step[6] = 20'($urandom_range(1, 1048575));

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // every slot written before any evaluate can read it, extremes at the ends
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      case (k)
        0, 62:   request_queue.push_back(load_request(k, 24'sh7fffff));
        1, 63:   request_queue.push_back(load_request(k, -24'sh800000));
        2:       request_queue.push_back(load_request(k, 24'sd0));
        default: request_queue.push_back(load_request(k, C_W'($urandom)));
      endcase
    end
    play_requests();

    // directed evaluates under reset registers: interval edges around both
    // ends of the table, zero and full fraction, x extremes, and a load
    // read back by the very next request
    foreach (edge_m[k]) begin
      request_queue.push_back(eval_request(x_on_grid(edge_m[k], 0)));
      request_queue.push_back(eval_request(x_on_grid(edge_m[k], 4095)));
    end
    request_queue.push_back(eval_request(-20'sd524288));
    request_queue.push_back(eval_request(20'sd524287));
    request_queue.push_back(eval_request(X_MIN_RST));
    request_queue.push_back(load_request(5, -24'sh800000));
    request_queue.push_back(eval_request(x_on_grid(4, 2048)));
    play_requests();

    // random traffic under the reset registers, then under each setting
    for (int ph = -1; ph < NUM_PHASES; ph++) begin
      if (ph >= 0) begin
        wait_idle();
        write_reg(CFG_X_MIN, phase_x_min[ph]);
        write_reg(CFG_INV_STEP, phase_inv_step[ph]);
        settings_used++;
      end
      repeat (RAND_PER_PHASE) request_queue.push_back(random_request());
      play_requests();
    end

    wait_idle();
    $display("covered %0d loads and %0d evaluates over %0d register settings",
             sb.loads_seen, sb.evals_seen, settings_used);
    $display("%0d results checked, %0d of them outside the table, %0d errors",
             sb.results_checked, sb.outside_seen, sb.errors);
    if (sb.errors == 0 && sb.pending_count() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+sv
sv/cbse_pkg.sv
sv/cbse_ram.sv
sv/cubic_bspline_evaluator.sv
tb/tb.sv
